// File: rtl/indexed_binary_heap_queue_core_defines.svh
// Assertion macros used by the checker file
`ifndef INDEXED_BINARY_HEAP_QUEUE_CORE_DEFINES_SVH
`define INDEXED_BINARY_HEAP_QUEUE_CORE_DEFINES_SVH

// Implication checked at every rising clock edge outside reset
`define IBHQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define IBHQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ibhq_pkg.sv
package ibhq_pkg;

  localparam int CAPACITY  = 64;
  localparam int ID_COUNT  = 256;
  localparam int KEY_BITS  = 16;
  localparam int SLOT_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int ID_BITS   = $clog2(ID_COUNT);

  // command codes
  localparam logic [2:0] FUNC_PUSH   = 3'd0;
  localparam logic [2:0] FUNC_POP    = 3'd1;
  localparam logic [2:0] FUNC_PEEK   = 3'd2;
  localparam logic [2:0] FUNC_CHANGE = 3'd3;
  localparam logic [2:0] FUNC_REMOVE = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_NOID   = 2'd3;

  // register indexes
  localparam logic [0:0] REG_SERVE_ORDER = 1'd0;
  localparam logic [0:0] REG_CAPACITY    = 1'd1;

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

endpackage

// File: rtl/indexed_binary_heap_queue_core.sv
// Indexed binary heap priority queue core.
// Input stream (in_*): one command word per handshake; tdata packs func[2:0],
// node_id[10:3], key[26:11]. Result stream (out_*): one word per command,
// tdata packs status[1:0], node_out[9:2], key_out[25:10], count[32:26].
// Config port: cfg_we with cfg_addr 0 = serve order, 1 = capacity.
// Sequence: with no sift the result follows the position lookup and tail
// read, the top or slot read and the decide step. A sift up adds a parent
// read and a compare per level moved, then places the entry; a sift down
// adds per level moved a left child read, a right child read and a pick
// when there is a right child, and a compare, then places it.
// Throughput: one command at a time; in_tready is low from the accepting
// edge until the result has been taken.
// The heap slots sit in memories with one write and one registered read per
// cycle, sequenced by one FSM around one shared key comparator.
// Reset: present bits and count clear, serve order goes to 0 and capacity
// to 64 in the reset cycle (present bits are flip-flops); no clearing pass.
// A result waits in the output register while out_tready is low; the next
// command is taken only once the result has gone.
module indexed_binary_heap_queue_core
  import ibhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // func, node_id, key
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status, node_out, key_out, count
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [6:0]  cfg_wdata
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LOOK   = 11'b00000000010,
    S_LOAD   = 11'b00000000100,
    S_EXEC   = 11'b00000001000,
    S_UPRD   = 11'b00000010000,
    S_UPCMP  = 11'b00000100000,
    S_DNRDL  = 11'b00001000000,
    S_DNRDR  = 11'b00010000000,
    S_DNPICK = 11'b00100000000,
    S_DNCMP  = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  id_t                 heap_ids [CAPACITY];
  key_t                heap_keys[CAPACITY];
  slot_t               slot_of_id[ID_COUNT];
  logic [ID_COUNT-1:0] present_r;
  cnt_t                count_r;
  logic                order_r;
  logic [6:0]          cap_r;

  logic [2:0] func_r;
  id_t        id_r;
  key_t       key_r;
  // entry being sifted and its current hole slot
  id_t        mid_r;
  key_t       mkey_r;
  slot_t      hole_r;
  // memory read data
  id_t        rid_r;
  key_t       rkey_r;
  slot_t      pos_r;
  logic       pres_r;
  // tail entry
  id_t        tid_r;
  key_t       tkey_r;
  // chosen child
  id_t        cid_r;
  key_t       ckey_r;
  slot_t      cslot_r;
  logic [1:0] status_r;
  id_t        nout_r;
  key_t       kout_r;

  // heap memory control
  logic  wr_en;
  slot_t wr_slot;
  id_t   wr_id;
  key_t  wr_key;
  slot_t rd_slot;
  logic  rd_en;

  // shared comparator: a served strictly before b
  key_t cmp_a, cmp_b;
  logic ahead;
  assign ahead = order_r ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

  logic [CNT_BITS:0] c_left, c_right, cnt_ext;
  assign c_left  = {1'b0, hole_r, 1'b1};
  assign c_right = c_left + (CNT_BITS+1)'(1);
  assign cnt_ext = {1'b0, count_r};

  slot_t par_slot;
  assign par_slot = slot_t'((hole_r - slot_t'(1)) >> 1);

  slot_t last_slot;
  assign last_slot = slot_t'(count_r - cnt_t'(1));

  cnt_t limit;
  assign limit = (cap_r > 7'(CAPACITY)) ? cnt_t'(CAPACITY) : cnt_t'(cap_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, count_r, kout_r, nout_r, status_r};

  // memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_ids[wr_slot]  <= wr_id;
      heap_keys[wr_slot] <= wr_key;
      slot_of_id[wr_id]  <= wr_slot;
    end
    if (rd_en) begin
      rid_r  <= heap_ids[rd_slot];
      rkey_r <= heap_keys[rd_slot];
    end
    pos_r  <= slot_of_id[id_r];
    pres_r <= present_r[id_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
      cap_r   <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SERVE_ORDER: order_r <= cfg_wdata[0];
        REG_CAPACITY:    cap_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    wr_en = 1'b0; wr_slot = hole_r; wr_id = mid_r; wr_key = mkey_r;
    rd_en = 1'b0; rd_slot = '0;
    cmp_a = mkey_r; cmp_b = rkey_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOOK;
      S_LOOK: begin
        // tail entry read; position lookup in flight
        rd_en = 1'b1; rd_slot = last_slot; state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // top or the id's own slot
        rd_en = 1'b1;
        rd_slot = (func_r == FUNC_CHANGE || func_r == FUNC_REMOVE) ? pos_r : '0;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmp_a = (func_r == FUNC_REMOVE) ? tkey_r : key_r;
        cmp_b = rkey_r;
        case (func_r)
          FUNC_PUSH:
            state_nxt = (pres_r || count_r >= limit) ? S_OUT : S_UPRD;
          FUNC_POP:
            state_nxt = (count_r <= cnt_t'(1)) ? S_OUT : S_DNRDL;
          FUNC_CHANGE:
            if (!pres_r) state_nxt = S_OUT;
            else state_nxt = ahead ? S_UPRD : S_DNRDL;
          FUNC_REMOVE:
            if (!pres_r || pos_r == last_slot) state_nxt = S_OUT;
            else state_nxt = ahead ? S_UPRD : S_DNRDL;
          default: state_nxt = S_OUT;
        endcase
      end
      S_UPRD: begin
        if (hole_r == '0) begin
          wr_en = 1'b1; state_nxt = S_OUT;
        end else begin
          rd_en = 1'b1; rd_slot = par_slot; state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        wr_en = 1'b1;
        if (ahead) begin
          // parent moves down into the hole
          wr_id = rid_r; wr_key = rkey_r; state_nxt = S_UPRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DNRDL: begin
        if (c_left >= cnt_ext) begin
          wr_en = 1'b1; state_nxt = S_OUT;
        end else begin
          rd_en = 1'b1; rd_slot = slot_t'(c_left); state_nxt = S_DNRDR;
        end
      end
      S_DNRDR: begin
        if (c_right < cnt_ext) begin
          rd_en = 1'b1; rd_slot = slot_t'(c_right); state_nxt = S_DNPICK;
        end else begin
          state_nxt = S_DNCMP;
        end
      end
      S_DNPICK: begin
        // right child wins only when strictly ahead
        cmp_a = rkey_r; cmp_b = ckey_r; state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        cmp_a = ckey_r; cmp_b = mkey_r;
        wr_en = 1'b1;
        if (ahead) begin
          wr_id = cid_r; wr_key = ckey_r; state_nxt = S_DNRDL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      present_r <= '0;
      count_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          func_r   <= in_tdata[2:0];
          id_r     <= in_tdata[10:3];
          key_r    <= in_tdata[26:11];
          status_r <= ST_OK;
          nout_r   <= '0;
          kout_r   <= '0;
        end
        S_LOAD: begin
          tid_r  <= rid_r;
          tkey_r <= rkey_r;
        end
        S_EXEC: begin
          case (func_r)
            FUNC_PUSH: begin
              if (pres_r) begin
                status_r <= ST_NOID;
              end else if (count_r >= limit) begin
                status_r <= ST_FULL;
              end else begin
                present_r[id_r] <= 1'b1;
                count_r <= count_r + cnt_t'(1);
                mid_r <= id_r; mkey_r <= key_r;
                hole_r <= slot_t'(count_r);
              end
            end
            FUNC_POP, FUNC_PEEK: begin
              if (count_r == '0) begin
                status_r <= ST_EMPTY;
              end else begin
                nout_r <= rid_r; kout_r <= rkey_r;
                if (func_r == FUNC_POP) begin
                  present_r[rid_r] <= 1'b0;
                  count_r <= count_r - cnt_t'(1);
                  mid_r <= tid_r; mkey_r <= tkey_r; hole_r <= '0;
                end
              end
            end
            FUNC_CHANGE: begin
              if (!pres_r) begin
                status_r <= ST_NOID;
              end else begin
                mid_r <= id_r; mkey_r <= key_r; hole_r <= pos_r;
              end
            end
            FUNC_REMOVE: begin
              if (!pres_r) begin
                status_r <= ST_NOID;
              end else begin
                present_r[id_r] <= 1'b0;
                count_r <= count_r - cnt_t'(1);
                mid_r <= tid_r; mkey_r <= tkey_r; hole_r <= pos_r;
              end
            end
            default: ;
          endcase
        end
        S_UPCMP: if (ahead) hole_r <= par_slot;
        S_DNRDR: begin
          cid_r <= rid_r; ckey_r <= rkey_r;
          cslot_r <= slot_t'(c_left);
        end
        S_DNPICK: if (ahead) begin
          cid_r <= rid_r; ckey_r <= rkey_r;
          cslot_r <= slot_t'(c_right);
        end
        S_DNCMP: if (ahead) hole_r <= cslot_r;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ibhq_checker.sv
`include "indexed_binary_heap_queue_core_defines.svh"
module ibhq_checker
  import ibhq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  // a result word holds while stalled
  `IBHQ_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
  // never ready while a result waits
  `IBHQ_ASSERT_IMP(a_excl, clk, rst_n, out_tvalid, !in_tready, "ready with result pending")
  // a taken command leaves the block busy
  `IBHQ_ASSERT_NXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "took two commands")
  // count never exceeds capacity
  `IBHQ_ASSERT_IMP(a_cnt, clk, rst_n, out_tvalid, out_tdata[32:26] <= 7'(CAPACITY), "count overflow")
endmodule

bind indexed_binary_heap_queue_core ibhq_checker u_ibhq_checker (.*);

// File: dv/indexed_binary_heap_queue_core_test.sv
`timescale 1ns / 100ps

module indexed_binary_heap_queue_core_test;
  import ibhq_pkg::*;

  // Command and result word layouts, high bits first
  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  node_id;
    logic [2:0]  func;
  } cmd_word_t;

  typedef struct packed {
    logic [6:0]  count;
    logic [15:0] key_out;
    logic [7:0]  node_out;
    logic [1:0]  status;
  } rsp_word_t;

  // One row of the directed table; typed_status/typed_count are typed-in values
  typedef struct {
    logic [2:0]  func;
    logic [7:0]  node_id;
    logic [15:0] key;
    bit          has_typed;
    logic [1:0]  typed_status;
    logic [6:0]  typed_count;
  } dir_row_t;

  localparam int TIMEOUT_CYCLES = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [6:0]  cfg_wdata;

  indexed_binary_heap_queue_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // func[2:0], node_id[10:3], key[26:11]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // status[1:0], node_out[9:2], key_out[25:10], count[32:26]
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Heap model state
  logic [7:0]  mdl_ids [CAPACITY];
  logic [15:0] mdl_keys [CAPACITY];
  int          mdl_slot [ID_COUNT];
  bit          mdl_present [ID_COUNT];
  int          mdl_count;
  bit          mdl_min_first;
  int          mdl_cap;

  rsp_word_t   expected_rsp [$];
  int          mismatches;
  int          cycle_cnt;
  int          sender_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Strictly-ahead compare under the current serve order
  function automatic bit served_first(logic [15:0] a, logic [15:0] b);
    return mdl_min_first ? (a < b) : (a > b);
  endfunction

  function automatic void put_slot(int s, logic [7:0] id, logic [15:0] k);
    mdl_ids[s]  = id;
    mdl_keys[s] = k;
    mdl_slot[id] = s;
  endfunction

  function automatic void bubble_up(int s);
    logic [7:0]  id;
    logic [15:0] k;
    int          up;
    id = mdl_ids[s];
    k  = mdl_keys[s];
    while (s > 0) begin
      up = (s - 1) >> 1;
      if (!served_first(k, mdl_keys[up])) break;
      put_slot(s, mdl_ids[up], mdl_keys[up]);
      s = up;
    end
    put_slot(s, id, k);
  endfunction

  function automatic void bubble_down(int s);
    logic [7:0]  id;
    logic [15:0] k;
    int          c;
    id = mdl_ids[s];
    k  = mdl_keys[s];
    forever begin
      c = 2 * s + 1;
      if (c >= mdl_count) break;
      if (c + 1 < mdl_count && served_first(mdl_keys[c+1], mdl_keys[c])) c++;
      if (!served_first(mdl_keys[c], k)) break;
      put_slot(s, mdl_ids[c], mdl_keys[c]);
      s = c;
    end
    put_slot(s, id, k);
  endfunction

  // Apply one command to the model and return its result word
  function automatic rsp_word_t heap_apply(cmd_word_t c);
    rsp_word_t   r;
    int          s, last, lim;
    logic [15:0] old;
    r = '0;
    lim = (mdl_cap < CAPACITY) ? mdl_cap : CAPACITY;
    case (c.func)
      FUNC_PUSH: begin
        if (mdl_present[c.node_id]) r.status = ST_NOID;
        else if (mdl_count >= lim) r.status = ST_FULL;
        else begin
          put_slot(mdl_count, c.node_id, c.key);
          mdl_present[c.node_id] = 1'b1;
          mdl_count++;
          bubble_up(mdl_count - 1);
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (mdl_count == 0) r.status = ST_EMPTY;
        else begin
          r.node_out = mdl_ids[0];
          r.key_out  = mdl_keys[0];
          if (c.func == FUNC_POP) begin
            last = mdl_count - 1;
            mdl_present[mdl_ids[0]] = 1'b0;
            mdl_count = last;
            if (last > 0) begin
              put_slot(0, mdl_ids[last], mdl_keys[last]);
              bubble_down(0);
            end
          end
        end
      end
      FUNC_CHANGE: begin
        if (!mdl_present[c.node_id]) r.status = ST_NOID;
        else begin
          s = mdl_slot[c.node_id];
          old = mdl_keys[s];
          mdl_keys[s] = c.key;
          if (served_first(c.key, old)) bubble_up(s);
          else bubble_down(s);
        end
      end
      FUNC_REMOVE: begin
        if (!mdl_present[c.node_id]) r.status = ST_NOID;
        else begin
          s = mdl_slot[c.node_id];
          last = mdl_count - 1;
          old = mdl_keys[s];
          mdl_present[c.node_id] = 1'b0;
          mdl_count = last;
          if (s != last) begin
            put_slot(s, mdl_ids[last], mdl_keys[last]);
            if (served_first(mdl_keys[s], old)) bubble_up(s);
            else bubble_down(s);
          end
        end
      end
      default: ;
    endcase
    r.count = mdl_count[6:0];
    return r;
  endfunction

  // Drive one command word until taken, honoring the sender idle rate;
  // tvalid stays up after the handshake until the next word or an idle
  task automatic drive_cmd(cmd_word_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {5'd0, c};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_cmd(cmd_word_t c);
    drive_cmd(c);
    expected_rsp.push_back(heap_apply(c));
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_SERVE_ORDER) mdl_min_first = val[0];
    else mdl_cap = int'(val);
  endtask

  // Receiver readiness, redrawn each falling edge
  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checking against the oldest expectation
  always @(posedge clk) begin
    rsp_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[32:0];
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_rsp.pop_front();
        if (got !== want || out_tdata[39:33] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: status %0d/%0d node %0d/%0d key %0d/%0d count %0d/%0d",
                     want.status, got.status, want.node_out, got.node_out,
                     want.key_out, got.key_out, want.count, got.count);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > TIMEOUT_CYCLES) begin
      $display("indexed_binary_heap_queue_core regression: fail");
      $finish;
    end
  end

  // Command mix including undefined codes: mostly ids from a small pool so change/remove hit
  function automatic cmd_word_t random_cmd();
    cmd_word_t c;
    int        pick;
    pick = $urandom_range(99);
    c.key = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
    c.node_id = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(40));
    if (pick < 35) c.func = FUNC_PUSH;
    else if (pick < 55) c.func = FUNC_POP;
    else if (pick < 65) c.func = FUNC_PEEK;
    else if (pick < 80) c.func = FUNC_CHANGE;
    else if (pick < 95) c.func = FUNC_REMOVE;
    else c.func = 3'($urandom_range(5, 7));
    return c;
  endfunction

  initial begin
    dir_row_t  dir_rows [$];
    cmd_word_t c;
    rsp_word_t r;
    int        phase, n;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    hold_off = 1'b0;
    mismatches = 0;
    cycle_cnt = 0;
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    mdl_count = 0;
    mdl_min_first = 1'b0;
    mdl_cap = 64;
    foreach (mdl_present[i]) mdl_present[i] = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: empty queue, extremes, ties, last-slot remove, bad codes
    dir_rows = '{
      '{FUNC_POP,    8'd0,   16'h0000, 1, ST_EMPTY, 7'd0},
      '{FUNC_PEEK,   8'd0,   16'h0000, 1, ST_EMPTY, 7'd0},
      '{FUNC_CHANGE, 8'd5,   16'h0001, 1, ST_NOID,  7'd0},
      '{FUNC_REMOVE, 8'd255, 16'h0000, 1, ST_NOID,  7'd0},
      '{FUNC_PUSH,   8'd255, 16'hFFFF, 1, ST_OK,    7'd1},
      '{FUNC_PUSH,   8'd255, 16'h0000, 1, ST_NOID,  7'd1},
      '{FUNC_PUSH,   8'd0,   16'h0000, 1, ST_OK,    7'd2},
      '{FUNC_PUSH,   8'd170, 16'h5555, 0, '0, '0},
      '{FUNC_PUSH,   8'd85,  16'hAAAA, 0, '0, '0},
      '{FUNC_PUSH,   8'd7,   16'h5555, 0, '0, '0},
      '{FUNC_PEEK,   8'd0,   16'h0000, 0, '0, '0},
      '{FUNC_CHANGE, 8'd0,   16'hFFFF, 0, '0, '0},
      '{FUNC_CHANGE, 8'd255, 16'h0001, 0, '0, '0},
      '{FUNC_REMOVE, 8'd7,   16'h0000, 0, '0, '0},
      '{3'd5,        8'd1,   16'h1234, 0, '0, '0},
      '{3'd6,        8'd1,   16'h1234, 0, '0, '0},
      '{3'd7,        8'd1,   16'h1234, 0, '0, '0},
      '{FUNC_POP,    8'd0,   16'h0000, 0, '0, '0},
      '{FUNC_REMOVE, 8'd85,  16'h0000, 0, '0, '0},
      '{FUNC_POP,    8'd0,   16'h0000, 0, '0, '0},
      '{FUNC_POP,    8'd0,   16'h0000, 0, '0, '0},
      '{FUNC_POP,    8'd0,   16'h0000, 1, ST_EMPTY, 7'd0}
    };
    foreach (dir_rows[i]) begin
      c.func = dir_rows[i].func;
      c.node_id = dir_rows[i].node_id;
      c.key = dir_rows[i].key;
      r = heap_apply(c);
      if (dir_rows[i].has_typed &&
          (r.status !== dir_rows[i].typed_status || r.count !== dir_rows[i].typed_count)) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d disagrees with typed result", i);
      end
      // only one command is ever outstanding, so queue the word first
      expected_rsp.push_back(r);
      drive_cmd(c);
    end
    drain_and_settle();

    // Capacity zero and one: push reports full once the queue holds that many
    write_reg(REG_CAPACITY, 7'd0);
    c = '{key: 16'd9, node_id: 8'd3, func: FUNC_PUSH};
    send_cmd(c);
    drain_and_settle();
    write_reg(REG_CAPACITY, 7'd1);
    send_cmd(c);
    c.node_id = 8'd4;
    send_cmd(c);
    c.func = FUNC_POP;
    send_cmd(c);
    drain_and_settle();
    write_reg(REG_CAPACITY, 7'd127);

    // Random phases across idle rates and register settings
    for (phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin sender_idle_pct = 15; recv_idle_pct = 81; end
        1: begin sender_idle_pct = 81; recv_idle_pct = 15; end
        default: begin sender_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(REG_SERVE_ORDER, 7'(phase & 1));
      write_reg(REG_CAPACITY, (phase == 3) ? 7'd8 : ((phase == 4) ? 7'd64 : 7'd100));
      if (phase == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (n = 0; n < 75; n++) send_cmd(random_cmd());
      drain_and_settle();
    end

    drain_and_settle();
    if (mismatches == 0 && expected_rsp.size() == 0)
      $display("indexed_binary_heap_queue_core regression: pass");
    else
      $display("indexed_binary_heap_queue_core regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ibhq_pkg.sv
rtl/indexed_binary_heap_queue_core.sv
rtl/ibhq_checker.sv
dv/indexed_binary_heap_queue_core_test.sv
